### design/bmd_pkg.sv
// shared types, constants and reset values of the bounce multitap delay unit
package bmd_pkg;

    localparam int BUFFER_DEPTH_DEF = 524288;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int MAX_TAPS_DEF     = 50;
    localparam int CHANNELS_DEF     = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 15;
    localparam int COUNT_W    = 6;
    localparam int GAIN_W     = 16;
    localparam int MUL_B_W    = 18;

    localparam logic [DELAY_W-1:0] DELAY_RST   = 15'd2400;
    localparam logic [COUNT_W-1:0] COUNT_RST   = 6'd24;
    localparam logic [15:0]        ELAST_RST   = 16'd16384;
    localparam logic [15:0]        DECAY_RST   = 16'd58982;
    localparam logic [15:0]        WET_RST     = 16'd9830;
    localparam logic [15:0]        UNITY_Q15   = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY   = 3'd0,
        CFG_COUNT   = 3'd1,
        CFG_ELAST   = 3'd2,
        CFG_DECAY   = 3'd3,
        CFG_WET     = 3'd4,
        CFG_SPLIT   = 3'd5,
        CFG_REVERSE = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_GAIN_MUL,
        ST_GAIN_UPD,
        ST_TAP,
        ST_RD2,
        ST_DIFF,
        ST_INTERP,
        ST_WEIGHT,
        ST_ACC,
        ST_OFF_UPD,
        ST_WET,
        ST_WETMUL,
        ST_MIX,
        ST_DONE
    } t_state;

endpackage

### design/bmd_in_if.sv
// input sample channel
interface bmd_in_if #(
    parameter int SAMPLE_WIDTH = bmd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           channel;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, channel, sample_in, input ready);
    modport sink   (input valid, channel, sample_in, output ready);
endinterface

### design/bmd_out_if.sv
// output sample channel
interface bmd_out_if #(
    parameter int SAMPLE_WIDTH = bmd_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic                           channel_out;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, channel_out, sample_out, input ready);
    modport sink   (input valid, channel_out, sample_out, output ready);
endinterface

### design/bounce_multitap_delay_unit.sv
// top level of the bounce multitap delay unit
// Each accepted transaction writes its sample into that channel's delay memory, then a small
// sequencer walks the taps with one shared multiplier and one memory read port: first it
// builds the gain powers (n multiply and update pairs plus a final check), then every tap
// that is used passes through two reads, the interpolation multiply, the gain multiply and
// the spacing multiply, while a skipped tap only gets the spacing multiply; after the tap
// loop the dry and wet parts are mixed. After reset a clearing pass zeroes the memory, one
// word a cycle, during which no sample is taken; configuration writes are taken at any
// time but should only be issued while the unit is idle. The result sits in an output
// register so a new sample can be taken while it waits.
module bounce_multitap_delay_unit #(
    parameter int BUFFER_DEPTH = bmd_pkg::BUFFER_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = bmd_pkg::SAMPLE_WIDTH_DEF,
    parameter int MAX_TAPS     = bmd_pkg::MAX_TAPS_DEF,
    parameter int CHANNELS     = bmd_pkg::CHANNELS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bmd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bmd_in_if.sink                            i_smp,
    bmd_out_if.source                         o_smp
);
    localparam int SW      = SAMPLE_WIDTH;
    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int MEM_D   = CHANNELS * BUFFER_DEPTH;
    localparam int MAW     = $clog2(MEM_D);
    localparam int TW      = $clog2(MAX_TAPS + 1);
    localparam int OFF_W   = AW + 8;
    localparam int OW1     = OFF_W + 4;
    localparam int MA_W    = (SW + 10 > OFF_W + 1) ? SW + 10 : OFF_W + 1;
    localparam int MB_W    = bmd_pkg::MUL_B_W;
    localparam int P_W     = MA_W + MB_W;
    localparam int ACC_W   = P_W + 7;
    localparam longint OFF_MAX = longint'(BUFFER_DEPTH - 2) * 256;

    // configuration registers
    logic [bmd_pkg::DELAY_W-1:0] r_delay;
    logic [bmd_pkg::COUNT_W-1:0] r_count;
    logic [15:0]                 r_elast;
    logic [15:0]                 r_decay;
    logic [15:0]                 r_wetmix;
    logic                        r_split;
    logic                        r_reverse;

    // sequencer and datapath registers
    bmd_pkg::t_state             r_state, n_state;
    logic [MAW-1:0]              r_clr;
    logic [AW-1:0]               r_wptr0, r_wptr1;
    logic                        r_ch, r_mch;
    logic signed [SW-1:0]        r_dry;
    logic [AW-1:0]               r_wp;
    logic [TW-1:0]               r_n, r_k, r_i;
    logic [16:0]                 r_e, r_w;
    logic [bmd_pkg::GAIN_W-1:0]  r_g;
    logic [bmd_pkg::GAIN_W-1:0]  r_pw [0:MAX_TAPS];
    logic [bmd_pkg::GAIN_W-1:0]  r_gsel;
    logic [OFF_W-1:0]            r_off;
    logic [7:0]                  r_fr;
    logic [AW-1:0]               r_i2;
    logic signed [SW-1:0]        r_v1;
    logic signed [SW-1:0]        r_rdata;
    logic signed [MA_W-1:0]      r_interp;
    logic signed [P_W-1:0]       r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [MA_W-1:0]      r_wet;
    logic signed [P_W-1:0]       r_mix;
    logic signed [SW-1:0]        r_y;
    logic                        r_o_valid, r_o_ch;
    logic signed [SW-1:0]        r_o_smp;

    // sample memory, both channels in one array
    logic signed [SW-1:0]        mem [0:MEM_D-1];

    logic                        in_acc;
    logic                        tap_used;
    logic [TW-1:0]               ex;
    logic [AW:0]                 idx_sum, idx1_w;
    logic [AW-1:0]               idx1, idx2;
    logic [MAW-1:0]              ch_base, rd_addr, wr_addr;
    logic                        wr_en;
    logic signed [SW-1:0]        wr_data;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [P_W-1:0]       off_rnd;
    logic [OW1-1:0]              off_sum;
    logic signed [P_W:0]         mix_sum;
    logic signed [P_W:0]         y_full;
    logic signed [ACC_W-1:0]     wet_rnd;
    logic                        out_free;

    assign i_smp.ready       = (r_state == bmd_pkg::ST_IDLE);
    assign in_acc            = i_smp.valid && i_smp.ready;
    assign o_smp.valid       = r_o_valid;
    assign o_smp.channel_out = r_o_ch;
    assign o_smp.sample_out  = r_o_smp;
    assign out_free          = !r_o_valid || o_smp.ready;

    // tap bookkeeping
    assign tap_used = !r_split || (r_i[0] == r_ch);
    assign ex       = r_reverse ? TW'(r_n - r_i - TW'(1)) : TW'(r_i + TW'(1));
    assign idx_sum  = (AW+1)'(r_wp) + (AW+1)'(r_off[OFF_W-1:8]);
    assign idx1_w   = (idx_sum >= (AW+1)'(BUFFER_DEPTH)) ? idx_sum - (AW+1)'(BUFFER_DEPTH)
                                                         : idx_sum;
    assign idx1     = idx1_w[AW-1:0];
    assign idx2     = (idx1 == AW'(BUFFER_DEPTH - 1)) ? '0 : AW'(idx1 + AW'(1));
    assign ch_base  = r_mch ? MAW'(BUFFER_DEPTH) : '0;

    // spacing recurrence with rounding and saturation
    assign off_rnd  = (r_prod + P_W'(32768)) >>> 16;
    assign off_sum  = OW1'(off_rnd) + OW1'({r_delay, 8'b0});

    // final mix
    assign wet_rnd  = (r_acc + (ACC_W'(1) <<< 22)) >>> 23;
    assign mix_sum  = (P_W+1)'(r_mix) + (P_W+1)'(r_prod) + (P_W+1)'(16384);
    assign y_full   = mix_sum >>> 15;

    // next state, shared multiplier operands, memory ports
    always_comb begin
        n_state = r_state;
        mul_a   = '0;
        mul_b   = '0;
        rd_addr = ch_base + MAW'(idx1);
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        case (r_state)
            bmd_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                if (r_clr == MAW'(MEM_D - 1)) n_state = bmd_pkg::ST_IDLE;
            end
            bmd_pkg::ST_IDLE: begin
                if (in_acc) n_state = bmd_pkg::ST_WRITE;
            end
            bmd_pkg::ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = ch_base + MAW'(r_wp);
                wr_data = r_dry;
                n_state = bmd_pkg::ST_GAIN_MUL;
            end
            bmd_pkg::ST_GAIN_MUL: begin
                mul_a = MA_W'(r_g);
                mul_b = MB_W'(r_e);
                n_state = (r_k == r_n) ? bmd_pkg::ST_TAP : bmd_pkg::ST_GAIN_UPD;
            end
            bmd_pkg::ST_GAIN_UPD: n_state = bmd_pkg::ST_GAIN_MUL;
            bmd_pkg::ST_TAP: begin
                if (r_i == r_n) begin
                    n_state = bmd_pkg::ST_WET;
                end else if (tap_used) begin
                    n_state = bmd_pkg::ST_RD2;
                end else begin
                    mul_a   = MA_W'(r_off);
                    mul_b   = MB_W'(r_decay);
                    n_state = bmd_pkg::ST_OFF_UPD;
                end
            end
            bmd_pkg::ST_RD2: begin
                rd_addr = ch_base + MAW'(r_i2);
                n_state = bmd_pkg::ST_DIFF;
            end
            bmd_pkg::ST_DIFF: begin
                mul_a   = MA_W'((SW+1)'(r_rdata) - (SW+1)'(r_v1));
                mul_b   = MB_W'(r_fr);
                n_state = bmd_pkg::ST_INTERP;
            end
            bmd_pkg::ST_INTERP: n_state = bmd_pkg::ST_WEIGHT;
            bmd_pkg::ST_WEIGHT: begin
                mul_a   = r_interp;
                mul_b   = MB_W'(r_gsel);
                n_state = bmd_pkg::ST_ACC;
            end
            bmd_pkg::ST_ACC: begin
                mul_a   = MA_W'(r_off);
                mul_b   = MB_W'(r_decay);
                n_state = bmd_pkg::ST_OFF_UPD;
            end
            bmd_pkg::ST_OFF_UPD: n_state = bmd_pkg::ST_TAP;
            bmd_pkg::ST_WET: begin
                mul_a   = MA_W'(r_dry);
                mul_b   = MB_W'(17'd32768 - r_w);
                n_state = bmd_pkg::ST_WETMUL;
            end
            bmd_pkg::ST_WETMUL: begin
                mul_a   = r_wet;
                mul_b   = MB_W'(r_w);
                n_state = bmd_pkg::ST_MIX;
            end
            bmd_pkg::ST_MIX: n_state = bmd_pkg::ST_DONE;
            bmd_pkg::ST_DONE: begin
                if (out_free) n_state = bmd_pkg::ST_IDLE;
            end
            default: n_state = bmd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmd_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // sample memory ports
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        r_rdata <= mem[rd_addr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay   <= bmd_pkg::DELAY_RST;
            r_count   <= bmd_pkg::COUNT_RST;
            r_elast   <= bmd_pkg::ELAST_RST;
            r_decay   <= bmd_pkg::DECAY_RST;
            r_wetmix  <= bmd_pkg::WET_RST;
            r_split   <= 1'b1;
            r_reverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bmd_pkg::CFG_DELAY:   r_delay   <= i_cfg_data[bmd_pkg::DELAY_W-1:0];
                bmd_pkg::CFG_COUNT:   r_count   <= i_cfg_data[bmd_pkg::COUNT_W-1:0];
                bmd_pkg::CFG_ELAST:   r_elast   <= i_cfg_data;
                bmd_pkg::CFG_DECAY:   r_decay   <= i_cfg_data;
                bmd_pkg::CFG_WET:     r_wetmix  <= i_cfg_data;
                bmd_pkg::CFG_SPLIT:   r_split   <= i_cfg_data[0];
                bmd_pkg::CFG_REVERSE: r_reverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control counters, write pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_wptr0   <= '0;
            r_wptr1   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == bmd_pkg::ST_CLEAR) r_clr <= MAW'(r_clr + MAW'(1));
            if (r_state == bmd_pkg::ST_WRITE) begin
                // pointer moves down by one with wrap
                if (r_mch) r_wptr1 <= (r_wp == '0) ? AW'(BUFFER_DEPTH - 1) : AW'(r_wp - AW'(1));
                else       r_wptr0 <= (r_wp == '0) ? AW'(BUFFER_DEPTH - 1) : AW'(r_wp - AW'(1));
            end
            if (r_state == bmd_pkg::ST_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_smp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(mul_a * mul_b);
        case (r_state)
            bmd_pkg::ST_IDLE: begin
                r_ch  <= i_smp.channel;
                r_mch <= (CHANNELS > 1) ? i_smp.channel : 1'b0;
                r_dry <= i_smp.sample_in;
                r_wp  <= ((CHANNELS > 1) && i_smp.channel) ? r_wptr1 : r_wptr0;
                r_n   <= (7'(r_count) > 7'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(r_count);
                r_e   <= (r_elast > bmd_pkg::UNITY_Q15) ? 17'd32768 : 17'(r_elast);
                r_w   <= (r_wetmix > bmd_pkg::UNITY_Q15) ? 17'd32768 : 17'(r_wetmix);
            end
            bmd_pkg::ST_WRITE: begin
                r_pw[0] <= bmd_pkg::UNITY_Q15;
                r_g     <= bmd_pkg::UNITY_Q15;
                r_k     <= '0;
                r_i     <= '0;
                r_off   <= '0;
                r_acc   <= '0;
            end
            bmd_pkg::ST_GAIN_UPD: begin
                r_g               <= bmd_pkg::GAIN_W'((r_prod + P_W'(16384)) >>> 15);
                r_pw[TW'(r_k + TW'(1))] <= bmd_pkg::GAIN_W'((r_prod + P_W'(16384)) >>> 15);
                r_k               <= TW'(r_k + TW'(1));
            end
            bmd_pkg::ST_TAP: begin
                r_fr <= r_off[7:0];
                r_i2 <= idx2;
            end
            bmd_pkg::ST_RD2: r_v1 <= r_rdata;
            bmd_pkg::ST_INTERP: begin
                r_interp <= MA_W'($signed({r_v1, 8'b0})) + MA_W'(r_prod);
                // gain of this tap, fetched ahead of the weight multiply
                r_gsel   <= r_pw[ex];
            end
            bmd_pkg::ST_ACC: r_acc <= r_acc + ACC_W'(r_prod);
            bmd_pkg::ST_OFF_UPD: begin
                r_off <= (off_sum > OW1'(OFF_MAX)) ? OFF_W'(OFF_MAX) : OFF_W'(off_sum);
                r_i   <= TW'(r_i + TW'(1));
            end
            bmd_pkg::ST_WET: r_wet <= MA_W'(wet_rnd);
            bmd_pkg::ST_WETMUL: r_mix <= r_prod;
            bmd_pkg::ST_MIX: begin
                // saturate to the sample range
                if (y_full > (P_W+1)'((longint'(1) <<< (SW - 1)) - 1))
                    r_y <= SW'((longint'(1) <<< (SW - 1)) - 1);
                else if (y_full < -(P_W+1)'(longint'(1) <<< (SW - 1)))
                    r_y <= SW'(-(longint'(1) <<< (SW - 1)));
                else
                    r_y <= SW'(y_full);
            end
            bmd_pkg::ST_DONE: begin
                if (out_free) begin
                    r_o_ch  <= r_ch;
                    r_o_smp <= r_y;
                end
            end
            default: ;
        endcase
    end

endmodule

### design/bmd_chk.sv
// port checker of the bounce multitap delay unit and its bind
module bmd_chk #(
    parameter int SAMPLE_WIDTH = bmd_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic                    i_out_ch,
    input logic [SAMPLE_WIDTH-1:0] i_out_smp
);
    // one sample at a time: busy right after a transaction
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken twice in a row");

    // a new result only comes out of a busy period
    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without work");

    // no result appears while idle with no result pending and nothing accepted
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid && i_in_ready && !i_in_valid |=> !i_out_valid)
        else $error("result appeared while idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_ch)
            && $stable(i_out_smp))
        else $error("stalled result changed");
endmodule

bind bounce_multitap_delay_unit bmd_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_bmd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_smp.valid),
    .i_out_ready (o_smp.ready),
    .i_out_ch    (o_smp.channel_out),
    .i_out_smp   (o_smp.sample_out)
);

### bench/bounce_multitap_delay_unit_tb.sv
// self-checking testbench of the bounce multitap delay unit
`timescale 1ns / 1ps

module bounce_multitap_delay_unit_tb;

    // small memory keeps the clearing pass short; the offset clamp is still reached
    localparam int BD       = 4096;
    localparam int SW       = 24;
    localparam int TAPS_MAX = 50;
    localparam longint unsigned OFF_CLAMP = longint'(BD - 2) << 8;

    // predicts the mixed sample of every accepted transaction and checks results in order
    class echo_scoreboard;
        logic signed [SW-1:0] mem [2][BD];
        int unsigned          wptr [2];
        int unsigned          delay, count, elast, decay, wet, split, rev;
        logic [SW:0]          expected_q [$];
        int                   errors;

        function new();
            foreach (mem[c, a]) mem[c][a] = '0;
            wptr[0] = 0;
            wptr[1] = 0;
            delay  = bmd_pkg::DELAY_RST;
            count  = bmd_pkg::COUNT_RST;
            elast  = bmd_pkg::ELAST_RST;
            decay  = bmd_pkg::DECAY_RST;
            wet    = bmd_pkg::WET_RST;
            split  = 1;
            rev    = 0;
            errors = 0;
        endfunction

        function void set_reg(bmd_pkg::t_cfg_idx idx, int unsigned val);
            case (idx)
                bmd_pkg::CFG_DELAY:   delay = val & 16'h7FFF;
                bmd_pkg::CFG_COUNT:   count = val & 6'h3F;
                bmd_pkg::CFG_ELAST:   elast = val & 16'hFFFF;
                bmd_pkg::CFG_DECAY:   decay = val & 16'hFFFF;
                bmd_pkg::CFG_WET:     wet   = val & 16'hFFFF;
                bmd_pkg::CFG_SPLIT:   split = val & 1;
                bmd_pkg::CFG_REVERSE: rev   = val & 1;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_input(logic ch, logic signed [SW-1:0] smp);
            longint          gain [TAPS_MAX+1];
            longint unsigned off;
            longint          acc, dry, wmix, wet_sum, y, v1, v2, fr;
            int unsigned     wp, n, e, ex, i1, i2;
            logic [SW-1:0]   y_bits;
            wp  = wptr[ch];
            dry = smp;
            mem[ch][wp] = smp;
            n    = (count > TAPS_MAX) ? TAPS_MAX : count;
            e    = (elast > 32768) ? 32768 : elast;
            wmix = (wet > 32768) ? 32768 : wet;
            gain[0] = 32768;
            for (int k = 0; k < TAPS_MAX; k++)
                gain[k+1] = (gain[k] * e + 16384) >> 15;
            off = 0;
            acc = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (!split || (i & 1) == ch) begin
                    ex = rev ? n - (i + 1) : i + 1;
                    i1 = (wp + int'(off >> 8)) % BD;
                    i2 = (i1 + 1) % BD;
                    fr = off & 255;
                    v1 = mem[ch][i1];
                    v2 = mem[ch][i2];
                    acc += (v1 * 256 + fr * (v2 - v1)) * gain[ex];
                end
                // next bounce: D plus the shrunk previous offset, rounded to Q.8
                off = (longint'(delay) << 8) + ((off * decay + 32768) >> 16);
                if (off > OFF_CLAMP) off = OFF_CLAMP;
            end
            wet_sum = (acc + (64'sd1 <<< 22)) >>> 23;
            y = (dry * (32768 - wmix) + wet_sum * wmix + 16384) >>> 15;
            if (y > 64'sd8388607) y = 64'sd8388607;
            if (y < -64'sd8388608) y = -64'sd8388608;
            y_bits = y[SW-1:0];
            wptr[ch] = (wp + BD - 1) % BD;
            expected_q.push_back({ch, y_bits});
        endfunction

        function void check(logic ch, logic [SW-1:0] smp);
            logic [SW:0] exp_item;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result ch=%0d sample=%0d",
                         $time, ch, $signed(smp));
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (exp_item[SW] !== ch) begin
                $display("%0t: channel mismatch expected %0d actual %0d",
                         $time, exp_item[SW], ch);
                errors++;
            end
            if (exp_item[SW-1:0] !== smp) begin
                $display("%0t: sample mismatch expected %0d actual %0d",
                         $time, $signed(exp_item[SW-1:0]), $signed(smp));
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [bmd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [bmd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    bmd_in_if  #(.SAMPLE_WIDTH(SW)) smp_in ();
    bmd_out_if #(.SAMPLE_WIDTH(SW)) smp_out ();

    bounce_multitap_delay_unit #(
        .BUFFER_DEPTH(BD),
        .SAMPLE_WIDTH(SW),
        .MAX_TAPS    (TAPS_MAX),
        .CHANNELS    (2)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_smp     (smp_in),
        .o_smp     (smp_out)
    );

    echo_scoreboard sb;

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, requested by the stimulus, counted down below
    int hold_req;
    int hold_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver: random stalls, or a long hold-off so the unit backs up
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            smp_out.ready <= 1'b0;
        end else begin
            smp_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // transaction monitor: note accepted inputs, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_in.valid && smp_in.ready)
                sb.note_input(smp_in.channel, smp_in.sample_in);
            if (smp_out.valid && smp_out.ready)
                sb.check(smp_out.channel_out, smp_out.sample_out);
        end
    end

    // offer one transaction, after an optional idle gap, and hold it until taken
    task automatic send_sample(logic ch, logic [SW-1:0] smp);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_in.valid     <= 1'b1;
        smp_in.channel   <= ch;
        smp_in.sample_in <= smp;
        do @(posedge i_clk); while (!smp_in.ready);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        smp_in.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(bmd_pkg::t_cfg_idx idx, int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[bmd_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        sb.set_reg(idx, 32'(val[bmd_pkg::CFG_DATA_W-1:0]));
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_config(int unsigned d, int unsigned n, int unsigned e,
                              int unsigned f, int unsigned w, int unsigned sp,
                              int unsigned rv);
        write_reg(bmd_pkg::CFG_DELAY, d);
        write_reg(bmd_pkg::CFG_COUNT, n);
        write_reg(bmd_pkg::CFG_ELAST, e);
        write_reg(bmd_pkg::CFG_DECAY, f);
        write_reg(bmd_pkg::CFG_WET, w);
        write_reg(bmd_pkg::CFG_SPLIT, sp);
        write_reg(bmd_pkg::CFG_REVERSE, rv);
    endtask

    // sample extremes on both channels
    task automatic send_extremes();
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'h7FFFFF);
        send_sample(1'b0, 24'h000000);
        send_sample(1'b1, 24'hFFFFFF);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return SW'($urandom_range(15));
            default: return SW'($urandom);
        endcase
    endfunction

    initial begin
        logic [SW-1:0] smp;
        int            n_taps;
        int            d_len;
        sb = new();
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        smp_in.valid     = 1'b0;
        smp_in.channel   = 1'b0;
        smp_in.sample_in = '0;
        smp_out.ready    = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_req         = 0;
        hold_left        = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, then the corner settings
        send_extremes();
        drain();
        // zero delay, too many bounces, gains above one, fully wet beyond one, reversed
        set_config(0, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1);
        send_extremes();
        drain();
        // longest delay so the offsets clamp, no decay, no gain, fully dry
        set_config(16'h7FFF, 50, 0, 0, 0, 1, 0);
        send_sample(1'b0, 24'h123456);
        send_sample(1'b1, 24'hEDCBA9);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        drain();
        // zero bounces, fully wet: output must be zero
        set_config(3, 0, 32768, 52429, 32768, 0, 0);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'h000001);
        send_sample(1'b1, 24'h555555);
        drain();

        // random phases: idle modes rotate; most phases use few short taps
        for (int p = 0; p < 10; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            n_taps = ($urandom_range(3) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
            d_len  = ($urandom_range(4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
            set_config(d_len, n_taps, $urandom_range(65535), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(1), $urandom_range(1));
            for (int k = 0; k < 100; k++) begin
                // back-pressure: hold results off while inputs keep coming
                if (p == 4 && k == 10) hold_req = 3000;
                smp = rand_sample();
                send_sample(1'($urandom_range(1)), smp);
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("bounce_multitap_delay_unit_tb: done, clean");
        end else begin
            $display("bounce_multitap_delay_unit_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("bounce_multitap_delay_unit_tb: done, errors");
        $finish;
    end

endmodule
